// File: design/mau_pkg.sv
// ----------------------------------------------------------------------------
// Modular arithmetic unit package
// Action codes, controller states and the command/status structs that pass
// between the controller and the datapath.
// ----------------------------------------------------------------------------
package mau_pkg;

  localparam int ActionW = 3;

  typedef enum logic [ActionW-1:0] {
    ACT_REDUCE = 3'd0,
    ACT_ADD    = 3'd1,
    ACT_SUB    = 3'd2,
    ACT_MUL    = 3'd3,
    ACT_NEG    = 3'd4,
    ACT_INV    = 3'd5
  } action_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_RED_A,
    ST_RED_B,
    ST_EXEC,
    ST_MUL,
    ST_INV_DIV,
    ST_INV_MUL,
    ST_INV_UPD,
    ST_DONE
  } state_t;

  // Datapath operations requested by the controller.
  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_RED_INIT_A,
    OP_RED_INIT_B,
    OP_DIV_STEP,
    OP_RED_END_A,
    OP_RED_END_B,
    OP_EXEC,
    OP_MUL_INIT,
    OP_MUL_STEP,
    OP_INV_INIT,
    OP_QDIV_INIT,
    OP_QMUL_INIT,
    OP_INV_UPD,
    OP_INV_END
  } dp_op_t;

  typedef struct packed {
    dp_op_t op;
  } mau_cmd_t;

  typedef struct packed {
    logic    step_last; // iteration counter reached its final step
    logic    r1_zero;   // Euclid remainder is zero
    action_t action;
  } mau_sts_t;

endpackage

// File: design/mau_datapath.sv
// ----------------------------------------------------------------------------
// Modular arithmetic unit datapath
// Shared restoring divider, shift-and-add modular multiplier and the
// extended Euclid registers, driven one step a cycle by the controller.
// ----------------------------------------------------------------------------
module mau_datapath #(
  parameter int DATA_WIDTH = 32
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic [31:0]            modulus,
  input  logic [2:0]             in_action,
  input  logic [31:0]            in_a,
  input  logic [31:0]            in_b,
  input  mau_pkg::mau_cmd_t      cmd,
  output mau_pkg::mau_sts_t      sts,
  output logic [31:0]            res_value,
  output logic                   res_flag
);
  import mau_pkg::*;

  localparam int W  = DATA_WIDTH;
  localparam int CW = $clog2(W + 1);

  logic [W-1:0]  n_eff;
  logic [W-1:0]  a_r, b_r, a_nxt, b_nxt;
  logic [W-1:0]  rem_r, rem_nxt, quo_r, quo_nxt, dvd_r, dvd_nxt, dvs_r, dvs_nxt;
  logic [W-1:0]  acc_r, acc_nxt, mx_r, mx_nxt, my_r, my_nxt;
  logic [W-1:0]  r0_r, r0_nxt, r1_r, r1_nxt, t0_r, t0_nxt, t1_r, t1_nxt;
  logic [W-1:0]  res_r, res_nxt;
  logic          flag_r, flag_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  action_t       act_r, act_nxt;
  logic [W:0]    rem_sh, rem_sub;
  logic [W-1:0]  rem_step;
  logic [W:0]    dbl, dbl_s, dad, dad_s;
  logic [W-1:0]  acc_d, acc_a;
  logic [W:0]    sum_w;
  logic [W-1:0]  in_a_w, in_b_w;

  assign in_a_w = W'(in_a);
  assign in_b_w = W'(in_b);
  assign n_eff  = (W'(modulus) == '0) ? W'(1) : W'(modulus);

  // Restoring division: one quotient bit a step.
  assign rem_sh   = {rem_r, dvd_r[W-1]};
  assign rem_sub  = rem_sh - {1'b0, dvs_r};
  assign rem_step = rem_sub[W] ? rem_sh[W-1:0] : rem_sub[W-1:0];

  // Modular multiply step: acc = 2*acc (+ x) mod n.
  assign dbl   = {acc_r, 1'b0};
  assign dbl_s = dbl - {1'b0, n_eff};
  assign acc_d = dbl_s[W] ? acc_r << 1 : dbl_s[W-1:0];
  assign dad   = {1'b0, acc_d} + {1'b0, mx_r};
  assign dad_s = dad - {1'b0, n_eff};
  assign acc_a = dad_s[W] ? dad[W-1:0] : dad_s[W-1:0];

  assign sum_w = {1'b0, a_r} + {1'b0, b_r};

  always_comb begin
    a_nxt = a_r; b_nxt = b_r; rem_nxt = rem_r; quo_nxt = quo_r;
    dvd_nxt = dvd_r; dvs_nxt = dvs_r; acc_nxt = acc_r; mx_nxt = mx_r;
    my_nxt = my_r; r0_nxt = r0_r; r1_nxt = r1_r; t0_nxt = t0_r; t1_nxt = t1_r;
    res_nxt = res_r; flag_nxt = flag_r; cnt_nxt = cnt_r; act_nxt = act_r;
    case (cmd.op)
      OP_LOAD: begin
        a_nxt    = in_a_w;
        b_nxt    = in_b_w;
        act_nxt  = action_t'(in_action);
        flag_nxt = 1'b0;
        res_nxt  = '0;
      end
      OP_RED_INIT_A, OP_RED_INIT_B, OP_QDIV_INIT: begin
        dvd_nxt = (cmd.op == OP_RED_INIT_A) ? a_r :
                  (cmd.op == OP_RED_INIT_B) ? b_r : r0_r;
        dvs_nxt = (cmd.op == OP_QDIV_INIT) ? r1_r : n_eff;
        rem_nxt = '0;
        quo_nxt = '0;
        cnt_nxt = '0;
      end
      OP_DIV_STEP: begin
        rem_nxt = rem_step;
        quo_nxt = {quo_r[W-2:0], ~rem_sub[W]};
        dvd_nxt = dvd_r << 1;
        cnt_nxt = cnt_r + CW'(1);
      end
      // The last division step is folded into the write-back of the operand.
      OP_RED_END_A: a_nxt = rem_step;
      OP_RED_END_B: b_nxt = rem_step;
      OP_EXEC: begin
        case (act_r)
          ACT_REDUCE: res_nxt = a_r;
          ACT_ADD: begin
            if (sum_w >= {1'b0, n_eff}) begin
              res_nxt = W'(sum_w - {1'b0, n_eff});
            end else begin
              res_nxt = sum_w[W-1:0];
            end
          end
          ACT_SUB: res_nxt = (a_r >= b_r) ? a_r - b_r : a_r + (n_eff - b_r);
          ACT_NEG: res_nxt = (a_r == '0) ? '0 : n_eff - a_r;
          default: res_nxt = '0;
        endcase
      end
      OP_MUL_INIT, OP_QMUL_INIT: begin
        acc_nxt = '0;
        cnt_nxt = '0;
        mx_nxt  = (cmd.op == OP_MUL_INIT) ? a_r : t1_r;
        // The quotient never exceeds n, so only q == n needs folding to zero.
        my_nxt  = (cmd.op == OP_MUL_INIT) ? b_r :
                  (quo_r == n_eff) ? '0 : quo_r;
      end
      OP_MUL_STEP: begin
        acc_nxt = my_r[W-1] ? acc_a : acc_d;
        my_nxt  = my_r << 1;
        cnt_nxt = cnt_r + CW'(1);
        res_nxt = my_r[W-1] ? acc_a : acc_d;
      end
      OP_INV_INIT: begin
        r0_nxt = n_eff;
        r1_nxt = a_r;
        t0_nxt = '0;
        t1_nxt = (n_eff == W'(1)) ? '0 : W'(1);
      end
      OP_INV_UPD: begin
        // rem_r holds r0 mod r1; acc_r holds (q mod n) * t1 mod n.
        r0_nxt = r1_r;
        r1_nxt = rem_r;
        t0_nxt = t1_r;
        t1_nxt = (t0_r >= acc_r) ? t0_r - acc_r : t0_r + (n_eff - acc_r);
      end
      OP_INV_END: begin
        if (r0_r == W'(1)) begin
          res_nxt = t0_r;
        end else begin
          res_nxt  = '0;
          flag_nxt = 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      act_r <= ACT_REDUCE;
      cnt_r <= '0;
    end else begin
      act_r <= act_nxt;
      cnt_r <= cnt_nxt;
    end
    a_r <= a_nxt; b_r <= b_nxt; rem_r <= rem_nxt; quo_r <= quo_nxt;
    dvd_r <= dvd_nxt; dvs_r <= dvs_nxt; acc_r <= acc_nxt; mx_r <= mx_nxt;
    my_r <= my_nxt; r0_r <= r0_nxt; r1_r <= r1_nxt; t0_r <= t0_nxt;
    t1_r <= t1_nxt; res_r <= res_nxt; flag_r <= flag_nxt;
  end

  assign sts.step_last = (cnt_r == CW'(W - 1));
  assign sts.r1_zero   = (r1_r == '0);
  assign sts.action    = act_r;
  assign res_value     = 32'(res_r);
  assign res_flag      = flag_r;

endmodule

// File: design/mau_controller.sv
// ----------------------------------------------------------------------------
// Modular arithmetic unit controller
// Sequences operand reduction, the selected action and the Euclid loop.
// ----------------------------------------------------------------------------
module mau_controller (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               req_valid,
  output logic               req_ready,
  output logic               res_valid,
  input  logic               res_ready,
  input  mau_pkg::mau_sts_t  sts,
  output mau_pkg::mau_cmd_t  cmd
);
  import mau_pkg::*;

  state_t state_r, state_nxt;
  logic   first_r, first_nxt; // first step of a phase pending its init

  always_comb begin
    state_nxt = state_r;
    first_nxt = 1'b0;
    case (state_r)
      ST_IDLE:  if (req_valid) begin
        state_nxt = ST_RED_A;
        first_nxt = 1'b1;
      end
      ST_RED_A: if (!first_r && sts.step_last) begin
        state_nxt = ST_RED_B;
        first_nxt = 1'b1;
      end
      ST_RED_B: if (!first_r && sts.step_last) begin
        state_nxt = ST_EXEC;
        first_nxt = 1'b1;
      end
      ST_EXEC: begin
        if (sts.action == ACT_MUL) begin
          state_nxt = ST_MUL;
        end else if (sts.action == ACT_INV) begin
          state_nxt = ST_INV_DIV;
        end else begin
          state_nxt = ST_DONE;
        end
        first_nxt = 1'b1;
      end
      ST_MUL: if (!first_r && sts.step_last) state_nxt = ST_DONE;
      ST_INV_DIV: begin
        if (first_r && sts.r1_zero) begin
          state_nxt = ST_DONE;
        end else if (!first_r && sts.step_last) begin
          state_nxt = ST_INV_MUL;
          first_nxt = 1'b1;
        end
      end
      ST_INV_MUL: if (!first_r && sts.step_last) state_nxt = ST_INV_UPD;
      ST_INV_UPD: begin
        state_nxt = ST_INV_DIV;
        first_nxt = 1'b1;
      end
      ST_DONE:  if (res_ready) state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd.op    = OP_NONE;
    req_ready = 1'b0;
    res_valid = 1'b0;
    case (state_r)
      ST_IDLE: begin
        req_ready = 1'b1;
        if (req_valid) cmd.op = OP_LOAD;
      end
      ST_RED_A: cmd.op = first_r ? OP_RED_INIT_A :
                         sts.step_last ? OP_RED_END_A : OP_DIV_STEP;
      ST_RED_B: cmd.op = first_r ? OP_RED_INIT_B :
                         sts.step_last ? OP_RED_END_B : OP_DIV_STEP;
      ST_EXEC: begin
        if (sts.action == ACT_MUL) begin
          cmd.op = OP_MUL_INIT;
        end else if (sts.action == ACT_INV) begin
          cmd.op = OP_INV_INIT;
        end else begin
          cmd.op = OP_EXEC;
        end
      end
      ST_MUL: cmd.op = first_r ? OP_NONE : OP_MUL_STEP;
      ST_INV_DIV: begin
        if (first_r) begin
          cmd.op = sts.r1_zero ? OP_INV_END : OP_QDIV_INIT;
        end else begin
          cmd.op = OP_DIV_STEP;
        end
      end
      ST_INV_MUL: cmd.op = first_r ? OP_QMUL_INIT : OP_MUL_STEP;
      ST_INV_UPD: cmd.op = OP_INV_UPD;
      ST_DONE:  res_valid = 1'b1;
      default:  cmd.op = OP_NONE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      first_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      first_r <= first_nxt;
    end
  end

endmodule

// File: design/modular_arithmetic_unit.sv
// ----------------------------------------------------------------------------
// Modular arithmetic unit
// Reduce, add, subtract, multiply, negate and inverse modulo a register n.
// ----------------------------------------------------------------------------
// Channel | Direction | Content
// in_     | slave     | tdata: action[2:0], operand_a[34:3], operand_b[66:35]
// out_    | master    | tdata: result_value[31:0]; tuser: no_inverse
// cfg_    | write     | modulus_n, 32 bits
//
// Every request first runs two W-step reductions by the shared restoring
// divider; multiply then adds W shift-and-add steps, and inverse runs Euclid
// rounds until the remainder is zero.
// Synchronous active-low reset returns to idle with modulus 1.
// A result holds on out_ until taken; a new request is taken after that.
// ----------------------------------------------------------------------------
module modular_arithmetic_unit #(
  parameter int DATA_WIDTH = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [71:0] in_tdata,   // action, operand_a, operand_b, zero pad
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // result_value
  output logic        out_tuser,  // no_inverse
  input  logic        cfg_wr_en,
  input  logic [31:0] cfg_wr_data
);
  import mau_pkg::*;

  logic [31:0] modulus_r;
  mau_cmd_t    cmd;
  mau_sts_t    sts;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      modulus_r <= 32'd1;
    end else if (cfg_wr_en) begin
      modulus_r <= cfg_wr_data;
    end
  end

  mau_controller u_ctrl (
    .clk(clk), .rst_n(rst_n),
    .req_valid(in_tvalid), .req_ready(in_tready),
    .res_valid(out_tvalid), .res_ready(out_tready),
    .sts(sts), .cmd(cmd)
  );

  mau_datapath #(.DATA_WIDTH(DATA_WIDTH)) u_dp (
    .clk(clk), .rst_n(rst_n), .modulus(modulus_r),
    .in_action(in_tdata[2:0]), .in_a(in_tdata[34:3]), .in_b(in_tdata[66:35]),
    .cmd(cmd), .sts(sts), .res_value(out_tdata), .res_flag(out_tuser)
  );

endmodule
